// ----- rtl/spt_pkg.sv -----
// Shared types and constants for the sorted pair table with nearest step.
`timescale 1ns / 1ps

package spt_pkg;

    localparam int DIM_W        = 14;
    localparam int COUNT_W      = 6;
    localparam int STATUS_W     = 3;
    localparam int AREA_W       = 2 * DIM_W;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;
    localparam int IN_PAD_W     = IN_TDATA_W - (2 * DIM_W + 2);
    localparam int OUT_PAD_W    = OUT_TDATA_W - (2 * DIM_W + COUNT_W);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_STEP   = 1'b1;

    localparam logic [1:0] DIR_NEXT = 2'b01;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_EXACT     = 3'd3,
        ST_NEAREST   = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        logic             load_want;
        logic [DIM_W-1:0] op_a;
        logic [DIM_W-1:0] op_b;
    } area_req_t;

endpackage

// ----- rtl/spt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spt_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/spt_area_unit.sv -----
// Shared area unit: multiplies a pair and returns its distance to a held target area.
`timescale 1ns / 1ps

module spt_area_unit (
    input  logic                          clk,
    input  spt_pkg::area_req_t            req,
    output logic [spt_pkg::AREA_W-1:0]    diff
);

    logic [spt_pkg::AREA_W-1:0] prod_reg;
    logic [spt_pkg::AREA_W-1:0] want_reg;
    logic [spt_pkg::AREA_W-1:0] diff_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= spt_pkg::AREA_W'(req.op_a) * spt_pkg::AREA_W'(req.op_b);
        if (req.load_want)
        begin
            want_reg <= prod_reg;
        end
        diff_reg <= (prod_reg >= want_reg) ? (prod_reg - want_reg) : (want_reg - prod_reg);
    end

    assign diff = diff_reg;

endmodule

// ----- rtl/sorted_pair_table_nearest_step.sv -----
// Top level of the sorted pair table: sequencer, table memory and shared area unit.
`timescale 1ns / 1ps
// The block keeps up to TABLE_DEPTH width/height pairs sorted by width, then height.
// Input beats arrive on s_tvalid/s_tready with the action on s_tuser; every input beat
// gives exactly one output beat on m_tvalid/m_tready, with the status on m_tuser.
// An insert adds a pair at its sorted place unless the table is full or holds it.
// A step finds the exact pair, or else the entry of closest area, moves at most one
// entry by the direction and returns that entry; a step on an empty table echoes the input.
// One item is worked at a time and s_tready is low until its result is registered.
// The table memory is scanned one entry a cycle through its single read port, then later
// entries shift one a cycle. An insert into a full table and a step on an empty table
// skip the scan. The result beat is registered as the block returns to idle. The result
// sits in an output register, so a new item is taken while it waits; if the receiver
// still stalls when the next result is ready, the block holds that result internally
// until the output register frees. Reset empties the table and drops any beat in
// flight; the table memory itself needs no clearing.
module sorted_pair_table_nearest_step #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [spt_pkg::IN_TDATA_W-1:0]    s_tdata,  // pair_width, pair_height, step_direction
    input  logic                              s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [spt_pkg::OUT_TDATA_W-1:0]   m_tdata,  // result_width, result_height, entry_count
    output logic [spt_pkg::STATUS_W-1:0]      m_tuser   // status
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = spt_pkg::DIM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_PICK,
        S_FETCH,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic                       act_reg;
    logic [DW-1:0]              w_reg;
    logic [DW-1:0]              h_reg;
    logic [1:0]                 dir_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              rd_idx_reg;
    logic                       want_load_reg;
    logic                       v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]              idx1_reg, idx2_reg, idx3_reg;
    logic                       exact_found_reg;
    logic [IW-1:0]              exact_idx_reg;
    logic                       after_found_reg;
    logic [IW-1:0]              at_reg;
    logic                       best_any_reg;
    logic [spt_pkg::AREA_W-1:0] closest_gap_reg;
    logic [IW-1:0]              best_idx_reg;
    logic                       sh_more_reg;
    logic [IW-1:0]              sh_idx_reg;
    logic                       sh_wv_reg;
    logic [IW-1:0]              sh_wa_reg;
    logic [IW-1:0]              cur_reg;
    logic [DW-1:0]              res_w_reg;
    logic [DW-1:0]              res_h_reg;
    spt_pkg::status_t           res_status_reg;
    logic                       out_valid_reg;
    logic [DW-1:0]              out_w_reg;
    logic [DW-1:0]              out_h_reg;
    logic [spt_pkg::COUNT_W-1:0] out_count_reg;
    spt_pkg::status_t           out_status_reg;

    logic [2*DW-1:0]            rdata;
    logic [DW-1:0]              rd_w;
    logic [DW-1:0]              rd_h;
    logic [IW-1:0]              raddr;
    logic                       we;
    logic [IW-1:0]              waddr;
    logic [2*DW-1:0]            wdata;
    spt_pkg::area_req_t         area_req;
    logic [spt_pkg::AREA_W-1:0] diff;
    logic                       scan_issue;
    logic                       scan_done;
    logic                       eq1;
    logic                       after1;
    logic                       s_accept;
    logic                       out_free;
    logic [IW-1:0]              base_idx;
    logic [IW-1:0]              cur_sel;

    assign rd_w = rdata[DW-1:0];
    assign rd_h = rdata[2*DW-1:DW];

    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign scan_issue = (state_reg == S_SCAN) && (rd_idx_reg < count_reg);
    assign scan_done  = (state_reg == S_SCAN) && !scan_issue && !v1_reg && !v2_reg && !v3_reg;
    assign eq1        = (rd_w == w_reg) && (rd_h == h_reg);
    assign after1     = (rd_w > w_reg) || ((rd_w == w_reg) && (rd_h > h_reg));

    always_comb
    begin
        base_idx = exact_found_reg ? exact_idx_reg : best_idx_reg;
        cur_sel  = base_idx;
        if (dir_reg == spt_pkg::DIR_NEXT)
        begin
            if ((CW'(base_idx) + CW'(1)) < count_reg)
            begin
                cur_sel = base_idx + IW'(1);
            end
        end
        else if (dir_reg[1])
        begin
            if (base_idx != '0)
            begin
                cur_sel = base_idx - IW'(1);
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            S_SHIFT: raddr = sh_idx_reg;
            S_PICK:  raddr = cur_reg;
            default: raddr = rd_idx_reg[IW-1:0];
        endcase
    end

    assign we    = ((state_reg == S_SHIFT) && sh_wv_reg) || (state_reg == S_WRITE);
    assign waddr = (state_reg == S_WRITE) ? at_reg : sh_wa_reg;
    assign wdata = (state_reg == S_WRITE) ? {h_reg, w_reg} : rdata;

    assign area_req.load_want = want_load_reg;
    assign area_req.op_a      = (state_reg == S_LOAD) ? w_reg : rd_w;
    assign area_req.op_b      = (state_reg == S_LOAD) ? h_reg : rd_h;

    spt_ram #(
        .WIDTH (2 * DW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    spt_area_unit u_area (
        .clk  (clk),
        .req  (area_req),
        .diff (diff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            act_reg         <= spt_pkg::ACT_INSERT;
            w_reg           <= '0;
            h_reg           <= '0;
            dir_reg         <= '0;
            count_reg       <= '0;
            rd_idx_reg      <= '0;
            want_load_reg   <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            idx1_reg        <= '0;
            idx2_reg        <= '0;
            idx3_reg        <= '0;
            exact_found_reg <= 1'b0;
            exact_idx_reg   <= '0;
            after_found_reg <= 1'b0;
            at_reg          <= '0;
            best_any_reg    <= 1'b0;
            closest_gap_reg <= '0;
            best_idx_reg    <= '0;
            sh_more_reg     <= 1'b0;
            sh_idx_reg      <= '0;
            sh_wv_reg       <= 1'b0;
            sh_wa_reg       <= '0;
            cur_reg         <= '0;
            res_w_reg       <= '0;
            res_h_reg       <= '0;
            res_status_reg  <= spt_pkg::ST_INSERTED;
            out_valid_reg   <= 1'b0;
            out_w_reg       <= '0;
            out_h_reg       <= '0;
            out_count_reg   <= '0;
            out_status_reg  <= spt_pkg::ST_INSERTED;
        end
        else
        begin
            want_load_reg <= (state_reg == S_LOAD);
            v1_reg        <= scan_issue;
            idx1_reg      <= rd_idx_reg[IW-1:0];
            v2_reg        <= v1_reg;
            idx2_reg      <= idx1_reg;
            v3_reg        <= v2_reg;
            idx3_reg      <= idx2_reg;

            if (out_valid_reg && m_tready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            if (scan_issue)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end

            if (v1_reg && eq1 && !exact_found_reg)
            begin
                exact_found_reg <= 1'b1;
                exact_idx_reg   <= idx1_reg;
            end
            if (v1_reg && after1 && !after_found_reg)
            begin
                after_found_reg <= 1'b1;
                at_reg          <= idx1_reg;
            end
            if (v3_reg && (!best_any_reg || (diff < closest_gap_reg)))
            begin
                best_any_reg    <= 1'b1;
                closest_gap_reg <= diff;
                best_idx_reg    <= idx3_reg;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        act_reg   <= s_tuser;
                        w_reg     <= s_tdata[DW-1:0];
                        h_reg     <= s_tdata[2*DW-1:DW];
                        dir_reg   <= s_tdata[2*DW+1:2*DW];
                        res_w_reg <= s_tdata[DW-1:0];
                        res_h_reg <= s_tdata[2*DW-1:DW];
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    rd_idx_reg      <= '0;
                    exact_found_reg <= 1'b0;
                    after_found_reg <= 1'b0;
                    best_any_reg    <= 1'b0;
                    if ((act_reg == spt_pkg::ACT_INSERT) && (count_reg >= CW'(TABLE_DEPTH)))
                    begin
                        res_status_reg <= spt_pkg::ST_FULL;
                        state_reg      <= S_FINISH;
                    end
                    else if ((act_reg == spt_pkg::ACT_STEP) && (count_reg == '0))
                    begin
                        res_status_reg <= spt_pkg::ST_EMPTY;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        if (act_reg == spt_pkg::ACT_INSERT)
                        begin
                            if (exact_found_reg)
                            begin
                                res_status_reg <= spt_pkg::ST_DUPLICATE;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                if (!after_found_reg)
                                begin
                                    at_reg <= count_reg[IW-1:0];
                                end
                                sh_more_reg <= after_found_reg;
                                sh_idx_reg  <= count_reg[IW-1:0] - IW'(1);
                                sh_wv_reg   <= 1'b0;
                                state_reg   <= S_SHIFT;
                            end
                        end
                        else
                        begin
                            cur_reg        <= cur_sel;
                            res_status_reg <= exact_found_reg ? spt_pkg::ST_EXACT
                                                              : spt_pkg::ST_NEAREST;
                            state_reg      <= S_PICK;
                        end
                    end
                end
                S_SHIFT:
                begin
                    sh_wv_reg <= sh_more_reg;
                    sh_wa_reg <= sh_idx_reg + IW'(1);
                    if (sh_more_reg)
                    begin
                        if (sh_idx_reg == at_reg)
                        begin
                            sh_more_reg <= 1'b0;
                        end
                        else
                        begin
                            sh_idx_reg <= sh_idx_reg - IW'(1);
                        end
                    end
                    else if (!sh_wv_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    count_reg      <= count_reg + CW'(1);
                    res_status_reg <= spt_pkg::ST_INSERTED;
                    state_reg      <= S_FINISH;
                end
                S_PICK:
                begin
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    res_w_reg <= rd_w;
                    res_h_reg <= rd_h;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_w_reg      <= res_w_reg;
                        out_h_reg      <= res_h_reg;
                        out_count_reg  <= spt_pkg::COUNT_W'(count_reg);
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= out_valid_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{spt_pkg::OUT_PAD_W{1'b0}}, out_count_reg, out_h_reg, out_w_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ----- rtl/spt_checker.sv -----
// Port-level checker for the sorted pair table, bound to the top level.
`timescale 1ns / 1ps

module spt_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [spt_pkg::IN_TDATA_W-1:0]    s_tdata,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [spt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic [spt_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int CNT_LO = 2 * spt_pkg::DIM_W;
    localparam int CNT_HI = CNT_LO + spt_pkg::COUNT_W - 1;

    logic [spt_pkg::COUNT_W-1:0] out_count;

    assign out_count = m_tdata[CNT_HI:CNT_LO];

    // The block is busy in the cycle after each accepted beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == spt_pkg::ST_EMPTY) |-> (out_count == '0))
        else $error("empty status with nonzero entry count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == spt_pkg::ST_FULL)
        |-> (out_count == spt_pkg::COUNT_W'(TABLE_DEPTH)))
        else $error("full status with table not full");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == spt_pkg::ST_INSERTED) |-> (out_count != '0))
        else $error("insert reported with empty table");

endmodule

bind sorted_pair_table_nearest_step spt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_spt_checker (.*);
